// File: rtl/bpdd_pkg.sv
package bpdd_pkg;

   localparam int NUM_BUTTONS     = 15;
   localparam int DIRECTION_COUNT = 8;
   localparam int LOAD_FIRST      = 8;
   localparam int LOAD_COUNT      = 6;
   localparam int AMP_BUTTON      = 14;

   localparam int COUNT_WIDTH = 8;
   localparam int LAMP_WIDTH  = 8;
   localparam int RELAY_WIDTH = 4;
   localparam int DRIVE_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_POLLS = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIVE_BYTES    = 8'd1;

   localparam logic [COUNT_WIDTH-1:0]    DEBOUNCE_RESET    = 8'd5;
   localparam logic [CSR_DATA_WIDTH-1:0] DRIVE_BYTES_RESET = 64'h8040_2010_0804_0201;

   typedef logic [NUM_BUTTONS-1:0] button_vec_type;

   // Fixed relay pattern for each direction button.
   function automatic logic [RELAY_WIDTH-1:0] relay_lookup(
      input logic [$clog2(DIRECTION_COUNT)-1:0] dir
   );
      logic [RELAY_WIDTH-1:0] pattern;
      case (dir)
         3'd0:    pattern = 4'b1000;
         3'd1:    pattern = 4'b1001;
         3'd2:    pattern = 4'b1100;
         3'd3:    pattern = 4'b0010;
         3'd4:    pattern = 4'b0000;
         3'd5:    pattern = 4'b0001;
         3'd6:    pattern = 4'b0100;
         3'd7:    pattern = 4'b1010;
         default: pattern = 4'b0000;
      endcase
      return pattern;
   endfunction

endpackage

// File: rtl/bpdd_lane.sv
module bpdd_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              poll_en,
   input  logic                              level,
   input  logic [bpdd_pkg::COUNT_WIDTH-1:0]  threshold,
   output logic                              press
);
   import bpdd_pkg::*;

   logic                   prev_ff, prev_in;
   logic                   deb_ff, deb_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   settled;

   // Saturating count of polls with an unchanged level.
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign settled   = (level == prev_ff) && (count_inc >= threshold);
   assign press     = settled && level && !deb_ff;

   always_comb begin
      prev_in  = prev_ff;
      deb_in   = deb_ff;
      count_in = count_ff;
      if (poll_en) begin
         if (level != prev_ff) begin
            prev_in  = level;
            count_in = '0;
         end else begin
            count_in = count_inc;
            if (settled) begin
               deb_in = level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         deb_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         deb_ff   <= deb_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/button_panel_debounce_driver_top.sv
// An accepted request is held in the input register, then moves on to the
// response register, which drives the response port. Throughput: one request
// per cycle while the response side does not stall; the fifteen debounce lanes
// update in parallel. While a finished response waits, the input register
// takes a request only if empty. Reset (synchronous, active high) clears all
// button state and outputs but the press mask and frame flag, and loads the
// threshold of five polls and the default drive bytes.
module button_panel_debounce_driver_top (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bpdd_pkg::NUM_BUTTONS-1:0]      req_button_levels_raw,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bpdd_pkg::NUM_BUTTONS-1:0]      rsp_press_mask,
   output logic [bpdd_pkg::LAMP_WIDTH-1:0]       rsp_lamp_pattern,
   output logic [bpdd_pkg::RELAY_WIDTH-1:0]      rsp_relay_pattern,
   output logic [bpdd_pkg::DRIVE_WIDTH-1:0]      rsp_direction_drive,
   output logic [bpdd_pkg::LOAD_COUNT-1:0]       rsp_load_pattern,
   output logic                                  rsp_amplifier_on,
   output logic                                  rsp_frame_sent,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bpdd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bpdd_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import bpdd_pkg::*;

   // Configuration registers. Writes must be issued only while the block is idle;
   // the block itself does not enforce this. The port is always ready.
   logic [COUNT_WIDTH-1:0]    threshold_ff, threshold_in;
   logic [CSR_DATA_WIDTH-1:0] drive_bytes_ff, drive_bytes_in;

   // Input register stage.
   logic           in_valid_ff, in_valid_in;
   button_vec_type in_raw_ff;
   logic           req_fire;

   // Response register stage and the action state it shows.
   logic                    rsp_valid_ff, rsp_valid_in;
   button_vec_type          press_ff;
   logic                    frame_ff;
   logic [LAMP_WIDTH-1:0]   lamp_ff, lamp_in;
   logic [RELAY_WIDTH-1:0]  relay_ff, relay_in;
   logic [DRIVE_WIDTH-1:0]  drive_ff, drive_in;
   logic [LOAD_COUNT-1:0]   load_ff, load_in;
   logic                    amp_ff, amp_in;
   logic                    frame_in;

   logic           out_blocked;
   logic           advance;
   button_vec_type press;
   button_vec_type level;

   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in   = threshold_ff;
      drive_bytes_in = drive_bytes_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_POLLS: threshold_in   = csr_data[COUNT_WIDTH-1:0];
            CSR_DRIVE_BYTES:    drive_bytes_in = csr_data;
            default: ;
         endcase
      end
   end

   // The request in the input register moves on unless the response register
   // holds a result that the far side has not yet taken.
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && out_blocked;
   assign req_fire    = req_valid && !req_stall;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance  ? 1'b1 : out_blocked;

   // Pins are active low; the lanes work with 1 meaning pressed.
   assign level = ~in_raw_ff;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      bpdd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .poll_en   (advance),
         .level     (level[i]),
         .threshold (threshold_ff),
         .press     (press[i])
      );
   end

   // Presses are applied in ascending button order, so the highest pressed
   // direction and the highest pressed load win.
   always_comb begin
      lamp_in  = lamp_ff;
      relay_in = relay_ff;
      drive_in = drive_ff;
      load_in  = load_ff;
      frame_in = 1'b0;
      for (int k = 0; k < DIRECTION_COUNT; k++) begin
         if (press[k]) begin
            lamp_in  = LAMP_WIDTH'(1) << k;
            relay_in = relay_lookup(3'(k));
            drive_in = drive_bytes_ff[k*DRIVE_WIDTH +: DRIVE_WIDTH];
            frame_in = 1'b1;
         end
      end
      for (int k = 0; k < LOAD_COUNT; k++) begin
         if (press[LOAD_FIRST+k]) begin
            load_in  = LOAD_COUNT'(1) << k;
            frame_in = 1'b1;
         end
      end
      amp_in = amp_ff ^ press[AMP_BUTTON];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= DEBOUNCE_RESET;
         drive_bytes_ff <= DRIVE_BYTES_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         lamp_ff        <= '0;
         relay_ff       <= '0;
         drive_ff       <= '0;
         load_ff        <= '0;
         amp_ff         <= 1'b0;
      end else begin
         threshold_ff   <= threshold_in;
         drive_bytes_ff <= drive_bytes_in;
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            lamp_ff  <= lamp_in;
            relay_ff <= relay_in;
            drive_ff <= drive_in;
            load_ff  <= load_in;
            amp_ff   <= amp_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_raw_ff <= req_button_levels_raw;
      end
      if (advance) begin
         press_ff <= press;
         frame_ff <= frame_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_press_mask      = press_ff;
   assign rsp_lamp_pattern    = lamp_ff;
   assign rsp_relay_pattern   = relay_ff;
   assign rsp_direction_drive = drive_ff;
   assign rsp_load_pattern    = load_ff;
   assign rsp_amplifier_on    = amp_ff;
   assign rsp_frame_sent      = frame_ff;

endmodule

// File: rtl/bpdd_checker.sv
module bpdd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [bpdd_pkg::NUM_BUTTONS-1:0]   rsp_press_mask,
   input logic [bpdd_pkg::LAMP_WIDTH-1:0]    rsp_lamp_pattern,
   input logic [bpdd_pkg::LOAD_COUNT-1:0]    rsp_load_pattern,
   input logic                               rsp_frame_sent
);
   import bpdd_pkg::*;

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A frame goes out exactly when a direction or load button was pressed.
   a_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_sent == (|rsp_press_mask[LOAD_FIRST+LOAD_COUNT-1:0])))
      else $error("frame flag does not match direction and load presses");

   // Lamp and load outputs select at most one entry.
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot0(rsp_lamp_pattern) && $onehot0(rsp_load_pattern)))
      else $error("lamp or load pattern not one-hot");

   // The top direction button, when pressed, owns the lamp.
   a_lamp_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_mask[DIRECTION_COUNT-1] |-> rsp_lamp_pattern[DIRECTION_COUNT-1])
      else $error("lamp does not follow the last direction press");

endmodule

bind button_panel_debounce_driver_top bpdd_checker u_bpdd_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import bpdd_pkg::*;

   // Clock period and how long the run may take before it is declared hung.
   localparam int  CLOCK_PERIOD  = 10;
   localparam int  RUN_LIMIT_NS  = 3_000_000;

   // The response side holds off once for a long stretch, after this many
   // requests have gone in, so that the pipeline fills and stalls its input.
   localparam int  HOLDOFF_AT     = 300;
   localparam int  HOLDOFF_CYCLES = 80;

   // Window of accepted requests during which neither side ever idles.
   localparam int  QUIET_FIRST = 700;
   localparam int  QUIET_LAST  = 1000;

   localparam logic [NUM_BUTTONS-1:0] ALL_RELEASED = '1;
   localparam logic [NUM_BUTTONS-1:0] ALL_PRESSED  = '0;

   // Relay bits for each direction button.
   localparam logic [RELAY_WIDTH-1:0] RELAY_BY_DIR [DIRECTION_COUNT] = '{
      4'h8, 4'h9, 4'hC, 4'h2, 4'h0, 4'h1, 4'h4, 4'hA
   };

   // One expected response, with a field for each response port.
   typedef struct packed {
      logic [NUM_BUTTONS-1:0] press_mask;
      logic [LAMP_WIDTH-1:0]  lamp;
      logic [RELAY_WIDTH-1:0] relay;
      logic [DRIVE_WIDTH-1:0] drive;
      logic [LOAD_COUNT-1:0]  load;
      logic                   amp;
      logic                   frame;
   } panel_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [NUM_BUTTONS-1:0]       req_button_levels_raw = '1;

   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [NUM_BUTTONS-1:0]       rsp_press_mask;
   logic [LAMP_WIDTH-1:0]        rsp_lamp_pattern;
   logic [RELAY_WIDTH-1:0]       rsp_relay_pattern;
   logic [DRIVE_WIDTH-1:0]       rsp_direction_drive;
   logic [LOAD_COUNT-1:0]        rsp_load_pattern;
   logic                         rsp_amplifier_on;
   logic                         rsp_frame_sent;

   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]    csr_data  = '0;

   button_panel_debounce_driver_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_button_levels_raw (req_button_levels_raw),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_press_mask        (rsp_press_mask),
      .rsp_lamp_pattern      (rsp_lamp_pattern),
      .rsp_relay_pattern     (rsp_relay_pattern),
      .rsp_direction_drive   (rsp_direction_drive),
      .rsp_load_pattern      (rsp_load_pattern),
      .rsp_amplifier_on      (rsp_amplifier_on),
      .rsp_frame_sent        (rsp_frame_sent),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // Polls waiting to be offered, and responses predicted but not yet seen.
   logic [NUM_BUTTONS-1:0] pending_polls [$];
   panel_result_type       expected_results [$];

   int  polls_queued   = 0;
   int  polls_accepted = 0;
   int  error_count    = 0;
   bit  req_fire       = 1'b0;
   int  holdoff_left   = 0;
   bit  holdoff_done   = 1'b0;

   // The predictor's copy of the configuration, as left by reset.
   logic [COUNT_WIDTH-1:0]    polls_threshold = DEBOUNCE_RESET;
   logic [CSR_DATA_WIDTH-1:0] drive_bytes     = DRIVE_BYTES_RESET;

   // The predictor's copy of the per-button lanes and the output registers.
   // A level of 1 here means pressed, the inverse of the pin.
   logic [NUM_BUTTONS-1:0] last_level = '0;
   logic [NUM_BUTTONS-1:0] settled_level = '0;
   logic [COUNT_WIDTH-1:0] steady_polls [NUM_BUTTONS] = '{default: '0};
   logic [LAMP_WIDTH-1:0]  lamp_now  = '0;
   logic [RELAY_WIDTH-1:0] relay_now = '0;
   logic [DRIVE_WIDTH-1:0] drive_now = '0;
   logic [LOAD_COUNT-1:0]  load_now  = '0;
   logic                   amp_now   = 1'b0;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Advances the button lanes by one poll and returns the response that the
   // block must give for it. Presses are applied from button 0 upward, so a
   // later press in the same poll overwrites what an earlier one set.
   function automatic panel_result_type predict_poll(input logic [NUM_BUTTONS-1:0] raw);
      panel_result_type r;
      logic             lvl;
      r = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         lvl = ~raw[i];
         if (lvl != last_level[i]) begin
            last_level[i]   = lvl;
            steady_polls[i] = '0;
         end else begin
            if (steady_polls[i] != COUNT_MAX)
               steady_polls[i] = steady_polls[i] + 1'b1;
            if (steady_polls[i] >= polls_threshold) begin
               if (lvl && !settled_level[i]) begin
                  r.press_mask[i] = 1'b1;
                  if (i < DIRECTION_COUNT) begin
                     lamp_now  = LAMP_WIDTH'(1) << i;
                     relay_now = RELAY_BY_DIR[i];
                     drive_now = drive_bytes[8*i +: 8];
                     r.frame   = 1'b1;
                  end else if (i < LOAD_FIRST + LOAD_COUNT) begin
                     load_now = LOAD_COUNT'(1) << (i - LOAD_FIRST);
                     r.frame  = 1'b1;
                  end else begin
                     amp_now = ~amp_now;
                  end
               end
               settled_level[i] = lvl;
            end
         end
      end
      r.lamp  = lamp_now;
      r.relay = relay_now;
      r.drive = drive_now;
      r.load  = load_now;
      r.amp   = amp_now;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Random idling at about 11 percent, except inside the quiet window.
   function automatic bit idle_now();
      if (polls_accepted >= QUIET_FIRST && polls_accepted <= QUIET_LAST)
         return 1'b0;
      return $urandom_range(0, 99) < 11;
   endfunction

   // Request driver. A new poll is put on the port at the falling edge only
   // once the previous one was taken at the rising edge, so a stalled request
   // holds its payload.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_polls.size() != 0 && !idle_now()) begin
            req_valid             <= 1'b1;
            req_button_levels_raw <= pending_polls.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall. Besides the random stalls, it holds off once for a long
   // stretch while requests keep coming, which backs up the pipeline.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && polls_accepted >= HOLDOFF_AT) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_now();
      end
   end

   // Monitor. At each rising edge an accepted request is run through the
   // predictor, and an accepted response is compared with the oldest
   // prediction, field by field.
   always @(posedge clock) begin : monitor
      panel_result_type want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            expected_results.push_back(predict_poll(req_button_levels_raw));
            polls_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding, press_mask 0x%0h",
                      rsp_press_mask);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("press_mask",      64'(want.press_mask), 64'(rsp_press_mask));
               check_field("lamp_pattern",    64'(want.lamp),   64'(rsp_lamp_pattern));
               check_field("relay_pattern",   64'(want.relay),  64'(rsp_relay_pattern));
               check_field("direction_drive", 64'(want.drive),  64'(rsp_direction_drive));
               check_field("load_pattern",    64'(want.load),   64'(rsp_load_pattern));
               check_field("amplifier_on",    64'(want.amp),    64'(rsp_amplifier_on));
               check_field("frame_sent",      64'(want.frame),  64'(rsp_frame_sent));
            end
         end
      end
   end

   task automatic queue_poll(input logic [NUM_BUTTONS-1:0] raw);
      pending_polls.push_back(raw);
      polls_queued++;
   endtask

   // One button gesture: an optional bounce, then a level held for a random
   // number of polls, most often just past the threshold so that it counts.
   task automatic queue_burst();
      logic [NUM_BUTTONS-1:0] pattern;
      int                     pick;
      int                     thr;
      int                     hold;
      pick = $urandom_range(0, 19);
      thr  = int'(polls_threshold);
      if (pick < 10)
         pattern = ALL_RELEASED & ~(NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1));
      else if (pick < 14)
         pattern = ~NUM_BUTTONS'($urandom & $urandom & $urandom);
      else if (pick < 17)
         pattern = ALL_RELEASED;
      else
         pattern = NUM_BUTTONS'($urandom);
      if ($urandom_range(0, 9) < 4) begin
         repeat ($urandom_range(1, 3))
            queue_poll(pattern ^ NUM_BUTTONS'($urandom & $urandom));
      end
      if ($urandom_range(0, 3) == 0)
         hold = $urandom_range(1, thr + 1);
      else
         hold = $urandom_range(thr + 1, thr + 3);
      repeat (hold) queue_poll(pattern);
   endtask

   task automatic fill_phase(input int budget);
      int start;
      start = polls_queued;
      while (polls_queued - start < budget) queue_burst();
   endtask

   // Register write, issued only while nothing is in flight. The predictor's
   // copy follows the write; unknown indexes leave it untouched.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_DEBOUNCE_POLLS)
         polls_threshold = value[COUNT_WIDTH-1:0];
      else if (idx == CSR_DRIVE_BYTES)
         drive_bytes = value;
   endtask

   // Waits until every queued poll has been taken and answered, then lets the
   // two pipeline stages settle a little longer.
   task automatic wait_for_drain();
      while (polls_accepted != polls_queued || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      // Reset is held from the start and released at a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed polls with the reset threshold of five. Pressing all buttons
      // at once reports every press in one poll, leaving the last direction and
      // load selected and the amplifier on. Releasing reports nothing, and the
      // bouncing patterns never stay long enough to count.
      queue_poll(ALL_RELEASED);
      repeat (6) queue_poll(ALL_PRESSED);
      repeat (6) queue_poll(ALL_RELEASED);
      repeat (2) begin
         queue_poll(15'h2AAA);
         queue_poll(15'h5555);
      end
      wait_for_drain();

      // A zero threshold accepts any unchanged level at the next poll.
      write_csr(CSR_DEBOUNCE_POLLS, '0);
      write_csr(CSR_DRIVE_BYTES, '1);
      repeat (2) queue_poll(15'h7FFE);
      repeat (2) queue_poll(ALL_RELEASED);
      repeat (2) queue_poll(15'h3FFF);
      queue_poll(ALL_RELEASED);
      fill_phase(150);
      wait_for_drain();

      // Writes to indexes that name no register must change nothing.
      write_csr(CSR_INDEX_WIDTH'(2), '1);
      write_csr('1, '0);

      // Threshold of one with random drive bytes; the long response
      // hold-off falls in this phase.
      write_csr(CSR_DEBOUNCE_POLLS, COUNT_WIDTH'(1));
      write_csr(CSR_DRIVE_BYTES, {$urandom, $urandom});
      fill_phase(400);
      wait_for_drain();

      // Back to the reset values; the stretch without idling falls here.
      write_csr(CSR_DEBOUNCE_POLLS, DEBOUNCE_RESET);
      write_csr(CSR_DRIVE_BYTES, DRIVE_BYTES_RESET);
      fill_phase(500);
      wait_for_drain();

      // Highest threshold, where the counters reach saturation.
      write_csr(CSR_DEBOUNCE_POLLS, COUNT_MAX);
      write_csr(CSR_DRIVE_BYTES, '0);
      fill_phase(600);
      wait_for_drain();

      // A random threshold from 2 to 20 and fresh drive bytes.
      write_csr(CSR_DEBOUNCE_POLLS, COUNT_WIDTH'($urandom_range(2, 20)));
      write_csr(CSR_DRIVE_BYTES, {$urandom, $urandom});
      fill_phase(300);
      wait_for_drain();

      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Hang guard, far beyond the slowest correct run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: button_panel_debounce_driver_top.f
rtl/bpdd_pkg.sv
rtl/bpdd_lane.sv
rtl/button_panel_debounce_driver_top.sv
rtl/bpdd_checker.sv
bench/tb_top.sv
